@@ rtl/core/otp_white_balance_gain_calc_core_assert.svh @@
// Assertion helpers for the white balance gain core.
// Both macros sample on clk_i and are disabled while rst_ni is low.
`ifndef OTP_WHITE_BALANCE_GAIN_CALC_CORE_ASSERT_SVH
`define OTP_WHITE_BALANCE_GAIN_CALC_CORE_ASSERT_SVH

// Property that must hold at every clock edge out of reset.
`define OTP_AWB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Antecedent in one cycle implies the consequent in the next.
`define OTP_AWB_ASSERT_NEXT(lbl, ante, cons, msg) \
  `OTP_AWB_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

@@ rtl/core/otp_awb_pkg.sv @@
package otp_awb_pkg;

  localparam int unsigned RatioW      = 10;  // raw ratio, light and typical width
  localparam int unsigned CorrW       = 11;  // corrected ratio width
  localparam int unsigned GainW       = 16;  // output gain width
  localparam int unsigned QueueDepth  = 2;
  localparam int unsigned CfgIdxW     = 1;

  localparam logic [CorrW-1:0]  LightOffset = 11'd512;
  localparam logic [RatioW-1:0] TypRgReset  = 10'hE7;
  localparam logic [RatioW-1:0] TypBgReset  = 10'h10F;
  localparam logic [GainW-1:0]  GainMax     = 16'hFFFF;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgTypRg = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgTypBg = 1'b1;

  typedef struct packed {
    logic              record_found;
    logic [RatioW-1:0] red_green_ratio;
    logic [RatioW-1:0] blue_green_ratio;
    logic [RatioW-1:0] light_red_green;
    logic [RatioW-1:0] light_blue_green;
  } in_t;

  typedef struct packed {
    logic [GainW-1:0] red_gain;
    logic [GainW-1:0] green_gain;
    logic [GainW-1:0] blue_gain;
    logic             red_write;
    logic             green_write;
    logic             blue_write;
    logic             divide_error;
  } out_t;

  // Branch taken for a record. Lo/Hi: corrected B/G then R/G against typical.
  typedef enum logic [2:0] {
    KindNoRec = 3'd0,
    KindErr   = 3'd1,
    KindLoLo  = 3'd2,
    KindLoHi  = 3'd3,
    KindHiLo  = 3'd4,
    KindHiHi  = 3'd5
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [CorrW-1:0]  rg;
    logic [CorrW-1:0]  bg;
    logic [RatioW-1:0] rt;
    logic [RatioW-1:0] bt;
  } cmd_t;

  typedef struct packed {
    logic start;
    logic long_div;  // full-width numerator; otherwise top RatioW bits are zero
  } div_req_t;

  typedef struct packed {
    logic done;
  } div_rsp_t;

endpackage

@@ rtl/core/otp_white_balance_gain_calc_core.sv @@
// White balance gain calculator for one camera module calibration record.
// A front stage takes one input transaction per cycle, applies the light
// source correction (ratio * (light + 512) / 1024 when light is nonzero),
// compares the corrected R/G and B/G with the typical ratios and pushes the
// chosen branch into a two-entry queue, so input is stalled only when that
// queue is full. The back end runs each record through two radix-2 restoring
// dividers, one quotient bit per cycle: first-level gains take
// GAIN_FRAC_BITS+11 iterations, the chained second gain GAIN_FRAC_BITS+21.
// A record without a division (no record found, or a zero ratio) goes
// straight to the output stage; one level of division runs when both
// measured ratios are below typical, and a chained second follows otherwise.
// Results leave through an output register, so the back end starts the next
// record while a result waits. Gains are Q(GAIN_FRAC_BITS), saturated to
// 16 bits; write flags mark gains above unity. Typical ratios are written
// through cfg_*_i (index 0 R/G, index 1 B/G); the user must do so only while
// no transaction is in flight, as the block itself does not enforce this.
module otp_white_balance_gain_calc_core #(
  parameter int unsigned GAIN_FRAC_BITS = 10
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  otp_awb_pkg::in_t                 in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output otp_awb_pkg::out_t                out_data_o,
  input  logic                             cfg_we_i,
  input  logic [otp_awb_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [otp_awb_pkg::RatioW-1:0]   cfg_data_i
);
  import otp_awb_pkg::*;

  localparam logic [GainW-1:0] UnityGain = GainW'(1) << GAIN_FRAC_BITS;

  // typical (golden) ratios
  logic [RatioW-1:0] typ_rg_q;
  logic [RatioW-1:0] typ_bg_q;

  // front to queue
  logic fifo_push;
  logic fifo_full;
  cmd_t fifo_wr_cmd;

  // queue to back end
  logic fifo_pop;
  logic fifo_empty;
  cmd_t fifo_rd_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      typ_rg_q <= TypRgReset;
      typ_bg_q <= TypBgReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgTypRg: typ_rg_q <= cfg_data_i;
        CfgTypBg: typ_bg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // correction and branch choice; typical ratios travel with the record
  otp_awb_front u_front (
    .in_valid_i,
    .in_data_i,
    .in_stall_o,
    .typ_rg_i     (typ_rg_q),
    .typ_bg_i     (typ_bg_q),
    .queue_full_i (fifo_full),
    .push_o       (fifo_push),
    .cmd_o        (fifo_wr_cmd)
  );

  otp_awb_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (fifo_push),
    .cmd_i   (fifo_wr_cmd),
    .full_o  (fifo_full),
    .pop_i   (fifo_pop),
    .empty_o (fifo_empty),
    .cmd_o   (fifo_rd_cmd)
  );

  // division sequencer, saturation and output register
  otp_awb_back #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_back (
    .clk_i,
    .rst_ni,
    .queue_empty_i (fifo_empty),
    .cmd_i         (fifo_rd_cmd),
    .pop_o         (fifo_pop),
    .out_valid_o,
    .out_stall_i,
    .out_data_o
  );

  `include "otp_white_balance_gain_calc_core_assert.svh"

  `OTP_AWB_ASSERT(a_no_push_when_full, !(fifo_push && fifo_full), "push into full queue")
  `OTP_AWB_ASSERT(a_no_pop_when_empty, !(fifo_pop && fifo_empty), "pop from empty queue")
  `OTP_AWB_ASSERT(a_err_zero_gains, !(out_valid_o && out_data_o.divide_error) || (out_data_o.red_gain == '0 && out_data_o.green_gain == '0 && out_data_o.blue_gain == '0), "error result with nonzero gain")
  `OTP_AWB_ASSERT(a_write_flags, !out_valid_o || (out_data_o.red_write == (out_data_o.red_gain > UnityGain) && out_data_o.green_write == (out_data_o.green_gain > UnityGain) && out_data_o.blue_write == (out_data_o.blue_gain > UnityGain)), "write flag mismatch")
  `OTP_AWB_ASSERT_NEXT(a_push_fills, fifo_push && !fifo_pop, !fifo_empty, "queue empty after push")

endmodule

@@ rtl/core/otp_awb_div.sv @@
module otp_awb_div #(
  parameter int unsigned NUM_W = 31
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  otp_awb_pkg::div_req_t          req_i,
  input  logic [NUM_W-1:0]               num_i,
  input  logic [otp_awb_pkg::CorrW-1:0]  den_i,
  output otp_awb_pkg::div_rsp_t          rsp_o,
  output logic [NUM_W-1:0]               quo_o
);
  import otp_awb_pkg::*;

  localparam int unsigned CntW      = $clog2(NUM_W + 1);
  localparam int unsigned ShortIter = NUM_W - RatioW;

  logic [NUM_W-1:0] num_q;
  logic [NUM_W-1:0] quo_q;
  logic [CorrW-1:0] rem_q;
  logic [CorrW-1:0] den_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [CorrW:0]   rem_sh;
  logic [CorrW:0]   rem_diff;
  logic             ge;
  logic [CorrW-1:0] rem_next;

  // restoring step, one quotient bit per cycle
  always_comb begin
    rem_sh   = {rem_q, num_q[NUM_W-1]};
    rem_diff = rem_sh - {1'b0, den_q};
    ge       = (rem_sh >= {1'b0, den_q});
    rem_next = ge ? rem_diff[CorrW-1:0] : rem_sh[CorrW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.long_div ? CntW'(NUM_W) : CntW'(ShortIter);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.long_div ? num_i : (num_i << RatioW);
      quo_q <= '0;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      num_q <= num_q << 1;
      quo_q <= {quo_q[NUM_W-2:0], ge};
      rem_q <= rem_next;
    end
  end

  assign quo_o      = quo_q;
  assign rsp_o.done = done_q;

endmodule

@@ rtl/core/otp_awb_front.sv @@
module otp_awb_front (
  input  logic                            in_valid_i,
  input  otp_awb_pkg::in_t                in_data_i,
  output logic                            in_stall_o,
  input  logic [otp_awb_pkg::RatioW-1:0]  typ_rg_i,
  input  logic [otp_awb_pkg::RatioW-1:0]  typ_bg_i,
  input  logic                            queue_full_i,
  output logic                            push_o,
  output otp_awb_pkg::cmd_t               cmd_o
);
  import otp_awb_pkg::*;

  localparam int unsigned ProdW = RatioW + CorrW;

  // ratio * (light + 512) / 1024, or the ratio itself when light is zero
  function automatic logic [CorrW-1:0] correct(input logic [RatioW-1:0] ratio,
                                               input logic [RatioW-1:0] light);
    logic [ProdW-1:0] prod;
    prod = ProdW'(ratio) * ProdW'({1'b0, light} + LightOffset);
    if (light == '0) begin
      return {1'b0, ratio};
    end
    return prod[ProdW-1:RatioW];
  endfunction

  logic [CorrW-1:0] rg;
  logic [CorrW-1:0] bg;
  logic             bg_lo;
  logic             rg_lo;

  always_comb begin
    rg    = correct(in_data_i.red_green_ratio, in_data_i.light_red_green);
    bg    = correct(in_data_i.blue_green_ratio, in_data_i.light_blue_green);
    bg_lo = (bg < {1'b0, typ_bg_i});
    rg_lo = (rg < {1'b0, typ_rg_i});

    cmd_o.rg = rg;
    cmd_o.bg = bg;
    cmd_o.rt = typ_rg_i;
    cmd_o.bt = typ_bg_i;
    if (!in_data_i.record_found) begin
      cmd_o.kind = KindNoRec;
    end else if (rg == '0 || bg == '0 || typ_rg_i == '0 || typ_bg_i == '0) begin
      cmd_o.kind = KindErr;
    end else if (bg_lo) begin
      cmd_o.kind = rg_lo ? KindLoLo : KindLoHi;
    end else begin
      cmd_o.kind = rg_lo ? KindHiLo : KindHiHi;
    end
  end

  assign in_stall_o = queue_full_i;
  assign push_o     = in_valid_i && !queue_full_i;

endmodule

@@ rtl/core/otp_awb_fifo.sv @@
module otp_awb_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  otp_awb_pkg::cmd_t  cmd_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output otp_awb_pkg::cmd_t  cmd_o
);
  import otp_awb_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cmd_t            entry_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign cmd_o   = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

@@ rtl/core/otp_awb_back.sv @@
module otp_awb_back #(
  parameter int unsigned GAIN_FRAC_BITS = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               queue_empty_i,
  input  otp_awb_pkg::cmd_t  cmd_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output otp_awb_pkg::out_t  out_data_o
);
  import otp_awb_pkg::*;

  localparam int unsigned Q1W = GAIN_FRAC_BITS + CorrW;   // first-level gain
  localparam int unsigned QW  = Q1W + RatioW;             // full-precision gain
  localparam logic [QW-1:0]    Unity  = QW'(1) << GAIN_FRAC_BITS;
  localparam logic [GainW-1:0] UnityO = GainW'(1) << GAIN_FRAC_BITS;

  typedef enum logic [3:0] {
    BackIdle = 4'b0001,
    BackDiv1 = 4'b0010,
    BackDiv2 = 4'b0100,
    BackFin  = 4'b1000
  } back_state_e;

  back_state_e state_q, state_d;
  cmd_t        cmd_q, cmd_d;
  logic [QW-1:0] r_q, r_d, g_q, g_d, b_q, b_d;
  logic        err_q, err_d;
  logic        dest_blue_q, dest_blue_d;
  logic        out_valid_q, out_valid_d;
  out_t        out_q, out_d;

  div_req_t      req_a, req_b;
  div_rsp_t      rsp_a, rsp_b;
  logic [QW-1:0] num_a, num_b, quo_a, quo_b;
  logic [CorrW-1:0] den_a, den_b;

  logic              hh_gb_gt;
  logic              to_blue;
  logic [Q1W-1:0]    mul_q;
  logic [RatioW-1:0] mul_t;
  logic [QW-1:0]     prod;
  logic              b_used;

  otp_awb_div #(.NUM_W(QW)) u_div_a (
    .clk_i, .rst_ni, .req_i(req_a), .num_i(num_a), .den_i(den_a),
    .rsp_o(rsp_a), .quo_o(quo_a)
  );

  otp_awb_div #(.NUM_W(QW)) u_div_b (
    .clk_i, .rst_ni, .req_i(req_b), .num_i(num_b), .den_i(den_b),
    .rsp_o(rsp_b), .quo_o(quo_b)
  );

  function automatic logic [GainW-1:0] sat(input logic [QW-1:0] v);
    return (|v[QW-1:GainW]) ? GainMax : v[GainW-1:0];
  endfunction

  // second-stage operand: the gain chosen in the first stage times a typical ratio
  always_comb begin
    hh_gb_gt = (quo_a > quo_b);
    to_blue  = (cmd_q.kind == KindLoHi) || (cmd_q.kind == KindHiHi && !hh_gb_gt);
    mul_q    = (cmd_q.kind == KindHiHi && !hh_gb_gt) ? quo_b[Q1W-1:0] : quo_a[Q1W-1:0];
    mul_t    = to_blue ? cmd_q.bt : cmd_q.rt;
    prod     = QW'(mul_q) * QW'(mul_t);
    b_used   = (cmd_q.kind == KindLoLo) || (cmd_q.kind == KindHiHi);
  end

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    r_d         = r_q;
    g_d         = g_q;
    b_d         = b_q;
    err_d       = err_q;
    dest_blue_d = dest_blue_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    pop_o       = 1'b0;
    req_a       = '0;
    req_b       = '0;
    num_a       = '0;
    num_b       = '0;
    den_a       = '0;
    den_b       = '0;

    case (state_q)
      BackIdle: begin
        if (!queue_empty_i) begin
          pop_o   = 1'b1;
          cmd_d   = cmd_i;
          err_d   = 1'b0;
          state_d = BackDiv1;
          case (cmd_i.kind)
            KindErr: begin
              r_d     = '0;
              g_d     = '0;
              b_d     = '0;
              err_d   = 1'b1;
              state_d = BackFin;
            end
            KindLoLo: begin
              g_d         = Unity;
              req_a.start = 1'b1;
              num_a       = QW'(cmd_i.bt) << GAIN_FRAC_BITS;
              den_a       = cmd_i.bg;
              req_b.start = 1'b1;
              num_b       = QW'(cmd_i.rt) << GAIN_FRAC_BITS;
              den_b       = cmd_i.rg;
            end
            KindLoHi: begin
              r_d         = Unity;
              req_a.start = 1'b1;
              num_a       = QW'(cmd_i.rg) << GAIN_FRAC_BITS;
              den_a       = {1'b0, cmd_i.rt};
            end
            KindHiLo: begin
              b_d         = Unity;
              req_a.start = 1'b1;
              num_a       = QW'(cmd_i.bg) << GAIN_FRAC_BITS;
              den_a       = {1'b0, cmd_i.bt};
            end
            KindHiHi: begin
              req_a.start = 1'b1;
              num_a       = QW'(cmd_i.bg) << GAIN_FRAC_BITS;
              den_a       = {1'b0, cmd_i.bt};
              req_b.start = 1'b1;
              num_b       = QW'(cmd_i.rg) << GAIN_FRAC_BITS;
              den_b       = {1'b0, cmd_i.rt};
            end
            default: begin
              // no calibration record
              r_d     = Unity;
              g_d     = Unity;
              b_d     = Unity;
              state_d = BackFin;
            end
          endcase
        end
      end

      BackDiv1: begin
        if (rsp_a.done && (rsp_b.done || !b_used)) begin
          if (cmd_q.kind == KindLoLo) begin
            b_d     = quo_a;
            r_d     = quo_b;
            state_d = BackFin;
          end else begin
            g_d            = QW'(mul_q);
            dest_blue_d    = to_blue;
            req_a.start    = 1'b1;
            req_a.long_div = 1'b1;
            num_a          = prod;
            den_a          = to_blue ? cmd_q.bg : cmd_q.rg;
            if (cmd_q.kind == KindHiHi) begin
              if (to_blue) begin
                r_d = Unity;
              end else begin
                b_d = Unity;
              end
            end
            state_d = BackDiv2;
          end
        end
      end

      BackDiv2: begin
        if (rsp_a.done) begin
          if (dest_blue_q) begin
            b_d = quo_a;
          end else begin
            r_d = quo_a;
          end
          state_d = BackFin;
        end
      end

      BackFin: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.red_gain     = sat(r_q);
          out_d.green_gain   = sat(g_q);
          out_d.blue_gain    = sat(b_q);
          out_d.red_write    = (sat(r_q) > UnityO);
          out_d.green_write  = (sat(g_q) > UnityO);
          out_d.blue_write   = (sat(b_q) > UnityO);
          out_d.divide_error = err_q;
          out_valid_d        = 1'b1;
          state_d            = BackIdle;
        end
      end

      default: begin
        state_d = BackIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BackIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    r_q         <= r_d;
    g_q         <= g_d;
    b_q         <= b_d;
    err_q       <= err_d;
    dest_blue_q <= dest_blue_d;
    out_q       <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
